/* src/block_frame_map_with_pin_eviction_defines.svh */
// Assertion macros used by the checker file.
`ifndef BLOCK_FRAME_MAP_WITH_PIN_EVICTION_DEFINES_SVH
`define BLOCK_FRAME_MAP_WITH_PIN_EVICTION_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define BFM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define BFM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* src/bfm_pkg.sv */
// Package with shared types, constants and codes of the block frame map.
package bfm_pkg;
	localparam int FRAMES_DEF = 16;
	localparam int BLOCKS_DEF = 8192;
	localparam int RECENT_DEF = 10;
	localparam int BLOCK_W = 13;
	localparam int OFFSET_W = 11;
	localparam int FRAME_W = 4;
	localparam int STATUS_W = 3;
	localparam int ST_ENTRY_W = 8;
	localparam int PIN_W = 16;
	localparam logic [7:0] ST_DISK = 8'd254;
	localparam logic [7:0] ST_EMPTY = 8'd255;
	localparam logic [PIN_W-1:0] PIN_MAX = 16'hFFFF;
	localparam logic [1:0] FUNC_PIN = 2'd0;
	localparam logic [1:0] FUNC_RELEASE = 2'd1;
	localparam logic [1:0] FUNC_VIEW = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [2:0] RES_HIT = 3'd0;
	localparam logic [2:0] RES_FETCH = 3'd1;
	localparam logic [2:0] RES_FRESH = 3'd2;
	localparam logic [2:0] RES_ALL_PINNED = 3'd3;
	localparam logic [2:0] RES_NOT_RESIDENT = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_RD_B, S_WAIT_B, S_RING_RD, S_RING_WAIT, S_DECIDE,
		S_SEARCH, S_EVICT_RD, S_EVICT_WAIT, S_EVICT_WR, S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_in;
		logic clear_step;
		logic rd_block;
		logic cap_block;
		logic rd_ring;
		logic cap_ring;
		logic decide;
		logic search_step;
		logic rd_owner;
		logic evict_wr;
		logic finish;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done;
		logic need_ring;
		logic need_search;
		logic search_done;
		logic found;
	} sts_t;
endpackage

/* src/bfm_ram.sv */
// Generic single-port RAM with registered read.
module bfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Single port, read data registered; a write cycle returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* src/bfm_ctrl.sv */
// Controller state machine of the block frame map.
module bfm_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input bfm_pkg::sts_t sts,
	output bfm_pkg::ctl_t ctl
);
	bfm_pkg::state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfm_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfm_pkg::S_CLEAR: if (sts.clear_done) state_d = bfm_pkg::S_IDLE;
			bfm_pkg::S_IDLE: if (start) state_d = bfm_pkg::S_RD_B;
			bfm_pkg::S_RD_B: state_d = bfm_pkg::S_WAIT_B;
			bfm_pkg::S_WAIT_B: begin
				if (sts.need_ring) state_d = bfm_pkg::S_RING_RD;
				else state_d = bfm_pkg::S_DECIDE;
			end
			bfm_pkg::S_RING_RD: state_d = bfm_pkg::S_RING_WAIT;
			bfm_pkg::S_RING_WAIT: state_d = bfm_pkg::S_DECIDE;
			bfm_pkg::S_DECIDE: begin
				if (sts.need_search) state_d = bfm_pkg::S_SEARCH;
				else state_d = bfm_pkg::S_DONE;
			end
			bfm_pkg::S_SEARCH: begin
				if (sts.search_done) begin
					if (sts.found) state_d = bfm_pkg::S_EVICT_RD;
					else state_d = bfm_pkg::S_DONE;
				end
			end
			bfm_pkg::S_EVICT_RD: state_d = bfm_pkg::S_EVICT_WAIT;
			bfm_pkg::S_EVICT_WAIT: state_d = bfm_pkg::S_EVICT_WR;
			bfm_pkg::S_EVICT_WR: state_d = bfm_pkg::S_DONE;
			bfm_pkg::S_DONE: state_d = bfm_pkg::S_IDLE;
			default: state_d = bfm_pkg::S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		ctl = '0;
		busy = (state_q != bfm_pkg::S_IDLE);
		unique case (state_q)
			bfm_pkg::S_CLEAR: ctl.clear_step = 1'b1;
			bfm_pkg::S_IDLE: ctl.latch_in = start;
			bfm_pkg::S_RD_B: ctl.rd_block = 1'b1;
			bfm_pkg::S_WAIT_B: ctl.cap_block = 1'b1;
			bfm_pkg::S_RING_RD: ctl.rd_ring = 1'b1;
			bfm_pkg::S_RING_WAIT: ctl.cap_ring = 1'b1;
			bfm_pkg::S_DECIDE: ctl.decide = 1'b1;
			bfm_pkg::S_SEARCH: ctl.search_step = 1'b1;
			bfm_pkg::S_EVICT_RD: ctl.rd_owner = 1'b1;
			bfm_pkg::S_EVICT_WAIT: ctl.rd_owner = 1'b0;
			bfm_pkg::S_EVICT_WR: ctl.evict_wr = 1'b1;
			bfm_pkg::S_DONE: ctl.finish = 1'b1;
			default: ctl = '0;
		endcase
	end
endmodule

/* src/bfm_datapath.sv */
// Datapath of the block frame map: status memory, frame tables, ring.
module bfm_datapath #(
	parameter int FRAMES = bfm_pkg::FRAMES_DEF,
	parameter int BLOCKS = bfm_pkg::BLOCKS_DEF,
	parameter int RECENT = bfm_pkg::RECENT_DEF
) (
	input logic clk,
	input logic arst_n,
	input bfm_pkg::ctl_t ctl,
	output bfm_pkg::sts_t sts,
	input logic [1:0] func,
	input logic [bfm_pkg::BLOCK_W-1:0] block,
	input logic [bfm_pkg::OFFSET_W-1:0] offset,
	output logic done,
	output logic [bfm_pkg::STATUS_W-1:0] status,
	output logic [bfm_pkg::FRAME_W-1:0] frame,
	output logic [bfm_pkg::OFFSET_W-1:0] offset_out,
	output logic writeback,
	output logic [bfm_pkg::BLOCK_W-1:0] victim_block
);
	localparam int AW = $clog2(BLOCKS);
	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RW = (RECENT > 1) ? $clog2(RECENT) : 1;
	localparam int FCW = $clog2(FRAMES + 1);

	// Latched request.
	logic [1:0] func_q;
	logic [AW-1:0] blk_q;
	logic [bfm_pkg::OFFSET_W-1:0] off_q;

	// Status memory port.
	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0] ram_wdata, ram_rdata;
	logic [AW-1:0] clr_q;

	// Frame tables and ring state.
	logic [AW-1:0] owner_q [FRAMES];
	logic [bfm_pkg::PIN_W-1:0] pin_q [FRAMES];
	logic [FW-1:0] vptr_q;
	logic [AW-1:0] ring_q [RECENT];
	logic ring_v_q [RECENT];
	logic [RW-1:0] rpos_q;
	logic [AW-1:0] last_q;
	logic last_v_q;

	// Per-item working registers.
	logic [7:0] s_q;
	logic [FW-1:0] srch_q;
	logic [FCW-1:0] scnt_q;
	logic [FW-1:0] cand_q;
	logic [AW-1:0] victim_q;
	logic [2:0] st_q;
	logic [FW-1:0] fr_q;
	logic wb_q;
	logic done_q;

	logic s_res, s_in_frame;
	logic view_repeat;
	logic view_repeat_rd;
	logic pin_zero_c;
	logic s_res_ring;
	logic [FW-1:0] s_fr;
	logic [FW-1:0] next_c;
	logic [FW-1:0] ring_fr;

	assign s_res = ({24'd0, ram_rdata} < 32'(FRAMES));
	assign s_in_frame = ({24'd0, s_q} < 32'(FRAMES));
	assign s_fr = s_q[FW-1:0];
	assign ring_fr = ram_rdata[FW-1:0];
	assign view_repeat = last_v_q && (last_q == blk_q) && s_in_frame;
	assign next_c = ({{(32-FW){1'b0}}, srch_q} == 32'(FRAMES - 1)) ? '0 : srch_q + 1'b1;

	// The repeat test at capture time uses the raw memory output.
	assign view_repeat_rd = last_v_q && (last_q == blk_q) && s_res;
	assign pin_zero_c = (pin_q[next_c] == '0);
	assign s_res_ring = s_res;

	// Status memory address and write data selection.
	always_comb begin
		ram_we = 1'b0;
		ram_addr = blk_q;
		ram_wdata = '0;
		priority if (ctl.clear_step) begin
			ram_we = 1'b1;
			ram_addr = clr_q;
			ram_wdata = ({{(32-AW){1'b0}}, clr_q} < 32'(FRAMES)) ?
				8'(clr_q) : bfm_pkg::ST_EMPTY;
		end else if (ctl.rd_ring) begin
			ram_addr = ring_q[rpos_q];
		end else if (ctl.rd_owner) begin
			ram_addr = owner_q[cand_q];
			ram_we = 1'b1;
			ram_wdata = bfm_pkg::ST_DISK;
		end else if (ctl.evict_wr) begin
			ram_we = 1'b1;
			ram_addr = blk_q;
			ram_wdata = {{(8-FW){1'b0}}, cand_q};
		end else begin
			ram_addr = blk_q;
		end
	end

	bfm_ram #(.WIDTH(8), .DEPTH(BLOCKS)) u_status (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// Clearing pass over the status memory after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clear_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign sts.clear_done = ctl.clear_step && (clr_q == AW'(BLOCKS - 1));
	assign sts.need_ring = (func_q == bfm_pkg::FUNC_VIEW) && !view_repeat_rd &&
		ring_v_q[rpos_q];
	assign sts.need_search = (func_q == bfm_pkg::FUNC_PIN ||
		(func_q == bfm_pkg::FUNC_VIEW && !view_repeat)) && !s_in_frame;
	assign sts.search_done = !pin_zero_c && (scnt_q == FCW'(FRAMES - 1)) || pin_zero_c;
	assign sts.found = pin_zero_c;

	// Main sequencing of per-item and table state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAMES; i++) begin
				owner_q[i] <= AW'(i % BLOCKS);
				pin_q[i] <= '0;
			end
			for (int i = 0; i < RECENT; i++) begin
				ring_v_q[i] <= 1'b0;
				ring_q[i] <= '0;
			end
			vptr_q <= '0;
			rpos_q <= '0;
			last_q <= '0;
			last_v_q <= 1'b0;
			done_q <= 1'b0;
			func_q <= '0;
			blk_q <= '0;
			off_q <= '0;
			s_q <= '0;
			srch_q <= '0;
			scnt_q <= '0;
			cand_q <= '0;
			victim_q <= '0;
			st_q <= '0;
			fr_q <= '0;
			wb_q <= 1'b0;
		end else begin
			done_q <= ctl.finish;
			if (ctl.latch_in) begin
				func_q <= func;
				blk_q <= block[AW-1:0];
				off_q <= offset;
				st_q <= bfm_pkg::RES_HIT;
				fr_q <= '0;
				wb_q <= 1'b0;
				victim_q <= '0;
			end
			if (ctl.cap_block) begin
				s_q <= ram_rdata;
			end
			// Unpin of the oldest ring entry.
			if (ctl.cap_ring) begin
				if (s_res_ring) begin
					if (pin_q[ring_fr] != '0) pin_q[ring_fr] <= pin_q[ring_fr] - 1'b1;
					// The current block may have been the ring entry's frame;
					// its count is read later from pin_q, so no bypass is needed.
				end
			end
			if (ctl.decide) begin
				srch_q <= vptr_q;
				scnt_q <= '0;
				unique case (func_q)
					bfm_pkg::FUNC_PIN: begin
						if (s_in_frame) begin
							if (pin_q[s_fr] != bfm_pkg::PIN_MAX) pin_q[s_fr] <= pin_q[s_fr] + 1'b1;
							fr_q <= s_fr;
						end
					end
					bfm_pkg::FUNC_RELEASE: begin
						if (s_in_frame) begin
							if (pin_q[s_fr] != '0) pin_q[s_fr] <= pin_q[s_fr] - 1'b1;
							fr_q <= s_fr;
						end else begin
							st_q <= bfm_pkg::RES_NOT_RESIDENT;
						end
					end
					bfm_pkg::FUNC_VIEW: begin
						if (view_repeat) begin
							fr_q <= s_fr;
						end else if (s_in_frame) begin
							if (pin_q[s_fr] != bfm_pkg::PIN_MAX) pin_q[s_fr] <= pin_q[s_fr] + 1'b1;
							fr_q <= s_fr;
							ring_q[rpos_q] <= blk_q;
							ring_v_q[rpos_q] <= 1'b1;
							rpos_q <= ({{(32-RW){1'b0}}, rpos_q} == 32'(RECENT - 1)) ?
								'0 : rpos_q + 1'b1;
							last_q <= blk_q;
							last_v_q <= 1'b1;
						end
					end
					default: fr_q <= '0;
				endcase
			end
			// Victim search, one frame a cycle.
			if (ctl.search_step) begin
				srch_q <= next_c;
				scnt_q <= scnt_q + 1'b1;
				if (pin_zero_c) begin
					cand_q <= next_c;
				end else if (scnt_q == FCW'(FRAMES - 1)) begin
					st_q <= bfm_pkg::RES_ALL_PINNED;
					if (func_q == bfm_pkg::FUNC_VIEW) ring_v_q[rpos_q] <= 1'b0;
				end
			end
			if (ctl.rd_owner) begin
				victim_q <= owner_q[cand_q];
			end
			// Take over the victim frame.
			if (ctl.evict_wr) begin
				wb_q <= 1'b1;
				owner_q[cand_q] <= blk_q;
				pin_q[cand_q] <= {{(bfm_pkg::PIN_W-1){1'b0}}, 1'b1};
				vptr_q <= cand_q;
				fr_q <= cand_q;
				st_q <= (s_q == bfm_pkg::ST_DISK) ? bfm_pkg::RES_FETCH : bfm_pkg::RES_FRESH;
				if (func_q == bfm_pkg::FUNC_VIEW) begin
					ring_q[rpos_q] <= blk_q;
					ring_v_q[rpos_q] <= 1'b1;
					rpos_q <= ({{(32-RW){1'b0}}, rpos_q} == 32'(RECENT - 1)) ?
						'0 : rpos_q + 1'b1;
					last_q <= blk_q;
					last_v_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign status = st_q;
	assign frame = (st_q >= bfm_pkg::RES_ALL_PINNED) ? '0 : bfm_pkg::FRAME_W'(fr_q);
	assign offset_out = off_q;
	assign writeback = wb_q;
	assign victim_block = bfm_pkg::BLOCK_W'(victim_q);
endmodule

/* src/block_frame_map_with_pin_eviction.sv */
// Top level of the block frame map with pin counts and clock eviction.
//  channel  | signals                                       | handshake
//  request  | func, block, offset                           | start && !busy
//  result   | status, frame, offset_out, writeback,         | done, one cycle
//           | victim_block                                  |
// A hit, a release or an undefined function passes S_RD_B, S_WAIT_B, S_DECIDE
// and S_DONE, then done is registered; the next beat can be accepted in the
// result cycle. A view adds the ring unpin (S_RING_RD, S_RING_WAIT) when its
// oldest ring entry is valid, unless it repeats the last view of a resident block.
// A miss adds the victim search over 1 to FRAMES frames, plus the eviction when
// a free frame is found. After reset a clearing pass writes the status memory,
// with busy high. Results cannot be stalled; done pulses once per beat.
module block_frame_map_with_pin_eviction #(
	parameter int FRAMES = bfm_pkg::FRAMES_DEF,
	parameter int BLOCKS = bfm_pkg::BLOCKS_DEF,
	parameter int RECENT = bfm_pkg::RECENT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] func,
	input logic [bfm_pkg::BLOCK_W-1:0] block,
	input logic [bfm_pkg::OFFSET_W-1:0] offset,
	output logic done,
	output logic [bfm_pkg::STATUS_W-1:0] status,
	output logic [bfm_pkg::FRAME_W-1:0] frame,
	output logic [bfm_pkg::OFFSET_W-1:0] offset_out,
	output logic writeback,
	output logic [bfm_pkg::BLOCK_W-1:0] victim_block
);
	bfm_pkg::ctl_t ctl;
	bfm_pkg::sts_t sts;

	// Controller.
	bfm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
	);

	// Datapath.
	bfm_datapath #(.FRAMES(FRAMES), .BLOCKS(BLOCKS), .RECENT(RECENT)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.func(func), .block(block), .offset(offset),
		.done(done), .status(status), .frame(frame), .offset_out(offset_out),
		.writeback(writeback), .victim_block(victim_block)
	);
endmodule

/* src/bfm_checker.sv */
// Port-level checker of the block frame map, with its bind.
`include "block_frame_map_with_pin_eviction_defines.svh"
module bfm_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [2:0] status,
	input logic [3:0] frame,
	input logic writeback,
	input logic [12:0] victim_block
);
	logic err_beat;
	logic miss_beat;

	assign err_beat = (status == bfm_pkg::RES_ALL_PINNED) ||
		(status == bfm_pkg::RES_NOT_RESIDENT);
	assign miss_beat = (status == bfm_pkg::RES_FETCH) || (status == bfm_pkg::RES_FRESH);

	`BFM_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accept did not raise busy")
	`BFM_ASSERT_IMP(a_done_busy, clk, arst_n, done, !busy, "result beat while still busy")
	`BFM_ASSERT_IMP(a_err_frame, clk, arst_n, done && err_beat, frame == 4'd0 && !writeback, "error beat")
	`BFM_ASSERT_IMP(a_wb_miss, clk, arst_n, done && writeback, miss_beat, "writeback without miss")
	`BFM_ASSERT_IMP(a_vb_zero, clk, arst_n, done && !writeback, victim_block == 13'd0, "stray victim")
endmodule

bind block_frame_map_with_pin_eviction bfm_checker u_bfm_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .frame(frame), .writeback(writeback), .victim_block(victim_block)
);
